// ===== hw/rtl/pms_pkg.sv =====
// Package for the pointer motion smoother.
// Holds configuration indexes, shared types and controller/datapath commands.
// No dependencies.
package pms_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [2:0] CFG_X_GAIN       = 3'd0;
    localparam logic [2:0] CFG_Y_GAIN       = 3'd1;
    localparam logic [2:0] CFG_HAND_SIDE    = 3'd2;
    localparam logic [2:0] CFG_SMOOTH_ALPHA = 3'd3;
    localparam logic [2:0] CFG_RISE_RATE    = 3'd4;
    localparam logic [2:0] CFG_FALL_RATE    = 3'd5;
    localparam logic [2:0] CFG_ACCEL_SCALE  = 3'd6;

    typedef struct packed {
        logic [11:0] x_gain;
        logic [11:0] y_gain;
        logic        hand_side;
        logic [15:0] smooth_alpha;
        logic [15:0] rise_rate;
        logic [15:0] fall_rate;
        logic [15:0] accel_scale;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_AX,
        OP_AY,
        OP_SQX,
        OP_SQY,
        OP_ENV,
        OP_FAC,
        OP_SCX,
        OP_SCY
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GAIN,
        ST_AX,
        ST_AX_WB,
        ST_AY,
        ST_AY_WB,
        ST_SQX,
        ST_SQX_WB,
        ST_SQY,
        ST_SQY_WB,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_ENV,
        ST_ENV_WB,
        ST_FAC,
        ST_FAC_WB,
        ST_SCX,
        ST_SCX_WB,
        ST_SCY,
        ST_SCY_WB,
        ST_ROUND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic gain;
        op_t  mul_op;
        op_t  wb_op;
        logic root_start;
        logic round;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic root_busy;
    } status_t;

    typedef struct packed {
        logic [7:0] move_x;
        logic [7:0] move_y;
        logic       moved;
    } res_t;

endpackage

// ===== hw/rtl/pms_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Does not depend on pms_pkg; no types used.
module pms_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic [63:0] n_reg, n_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            n_next    = radicand;
            res_next  = '0;
            bit_next  = 64'd1 << 62;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

// ===== hw/rtl/pms_dp.sv =====
// Datapath: gain, shared multiplier, averages, envelope, scaling and rounding.
// Depends on pms_pkg and pms_sqrt.
module pms_dp
    import pms_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    input  logic [31:0] in_data,
    output status_t     status,
    output res_t        result
);

    localparam int RW = FRACTION_BITS + 2;

    logic [31:0] in_reg;
    logic signed [31:0] gx_reg, gy_reg;
    logic signed [31:0] xavg_reg, yavg_reg;
    logic [31:0] env_reg;
    logic signed [RW-1:0] xres_reg, yres_reg;
    logic [63:0] sq_reg;
    logic [30:0] factor_reg;
    logic signed [63:0] scx_reg, scy_reg;
    logic signed [63:0] rx_reg, ry_reg;
    logic signed [67:0] prod_reg;
    logic signed [33:0] mul_a, mul_b;
    logic [31:0] len;
    logic root_busy;

    pms_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (sq_reg),
        .busy     (root_busy),
        .root     (len)
    );

    assign status.root_busy = root_busy;

    // gained delta, clamped to the signed 32-bit range
    function automatic logic signed [31:0] gain_axis(input logic [7:0] pos,
                                                     input logic [7:0] neg,
                                                     input logic [11:0] gain);
        logic signed [8:0]  d;
        logic signed [21:0] p;
        logic signed [47:0] v;
        d = $signed({1'b0, pos}) - $signed({1'b0, neg});
        p = 22'(d) * $signed({10'b0, gain});
        v = 48'(p) <<< (FRACTION_BITS - 8);
        if (v > 48'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -48'sh8000_0000) begin
            return -32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [63:0] round_fix(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q   = (mag + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [7:0] sat8(input logic signed [63:0] v);
        if (v > 64'sd127) begin
            return 8'h7F;
        end else if (v < -64'sd128) begin
            return 8'h80;
        end else begin
            return v[7:0];
        end
    endfunction

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            OP_AX: begin
                mul_a = 34'(gx_reg) - 34'(xavg_reg);
                mul_b = $signed({18'b0, cfg.smooth_alpha});
            end
            OP_AY: begin
                mul_a = 34'(gy_reg) - 34'(yavg_reg);
                mul_b = $signed({18'b0, cfg.smooth_alpha});
            end
            OP_SQX: begin
                mul_a = 34'(gx_reg);
                mul_b = 34'(gx_reg);
            end
            OP_SQY: begin
                mul_a = 34'(gy_reg);
                mul_b = 34'(gy_reg);
            end
            OP_ENV: begin
                mul_a = $signed({2'b0, len}) - $signed({2'b0, env_reg});
                mul_b = (len < env_reg) ? $signed({18'b0, cfg.fall_rate})
                                        : $signed({18'b0, cfg.rise_rate});
            end
            OP_FAC: begin
                mul_a = $signed({2'b0, env_reg});
                mul_b = $signed({18'b0, cfg.accel_scale});
            end
            OP_SCX: begin
                mul_a = 34'(xavg_reg);
                mul_b = $signed({3'b0, factor_reg});
            end
            OP_SCY: begin
                mul_a = 34'(yavg_reg);
                mul_b = $signed({3'b0, factor_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic signed [67:0] prod_s16;
    logic signed [67:0] prod_sf;
    logic [59:0]        prod_s8;
    logic signed [33:0] env_sum;
    logic signed [63:0] rx_new, ry_new;

    assign prod_s16 = prod_reg >>> 16;
    assign prod_sf  = prod_reg >>> FRACTION_BITS;
    assign prod_s8  = prod_reg[67:8];
    assign env_sum  = $signed({2'b0, env_reg}) + prod_s16[33:0];
    assign rx_new   = round_fix(scx_reg);
    assign ry_new   = round_fix(scy_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load_in) begin
            in_reg <= in_data;
        end
        if (cmd.gain) begin
            gx_reg <= gain_axis(in_reg[31:24], in_reg[23:16], cfg.x_gain);
            gy_reg <= gain_axis(in_reg[15:8], in_reg[7:0], cfg.y_gain);
        end
        case (cmd.wb_op)
            OP_SQX:  sq_reg <= prod_reg[63:0];
            OP_SQY:  sq_reg <= sq_reg + prod_reg[63:0];
            OP_FAC: begin
                if (prod_s8 < (60'd1 << FRACTION_BITS)) begin
                    factor_reg <= 31'(64'd1 << FRACTION_BITS);
                end else if (prod_s8 > 60'h7FFF_FFFF) begin
                    factor_reg <= 31'h7FFF_FFFF;
                end else begin
                    factor_reg <= prod_s8[30:0];
                end
            end
            OP_SCX:  scx_reg <= prod_sf[63:0] - 64'(xres_reg);
            OP_SCY:  scy_reg <= prod_sf[63:0] - 64'(yres_reg);
            default: begin
            end
        endcase
        if (cmd.round) begin
            rx_reg <= rx_new;
            ry_reg <= ry_new;
        end
    end

    // persistent filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xavg_reg <= '0;
            yavg_reg <= '0;
            env_reg  <= '0;
            xres_reg <= '0;
            yres_reg <= '0;
        end else begin
            case (cmd.wb_op)
                OP_AX: xavg_reg <= xavg_reg + prod_s16[31:0];
                OP_AY: yavg_reg <= yavg_reg + prod_s16[31:0];
                OP_ENV: begin
                    if (env_sum < 0) begin
                        env_reg <= '0;
                    end else if (env_sum > $signed({2'b0, 32'hFFFF_FFFF})) begin
                        env_reg <= 32'hFFFF_FFFF;
                    end else begin
                        env_reg <= env_sum[31:0];
                    end
                end
                default: begin
                end
            endcase
            if (cmd.round) begin
                xres_reg <= RW'((rx_new <<< FRACTION_BITS) - scx_reg);
                yres_reg <= RW'((ry_new <<< FRACTION_BITS) - scy_reg);
            end
        end
    end

    always_comb begin
        if (!cfg.hand_side) begin
            result.move_x = sat8(ry_reg);
            result.move_y = sat8(-rx_reg);
        end else begin
            result.move_x = sat8(-ry_reg);
            result.move_y = sat8(rx_reg);
        end
        result.moved = (rx_reg != 0) || (ry_reg != 0);
    end

endmodule

// ===== hw/rtl/pms_ctrl.sv =====
// Controller: sequences one report through the datapath operations.
// Depends on pms_pkg.
module pms_ctrl
    import pms_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    out_free,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mul_op     = OP_NONE;
        cmd.wb_op      = OP_NONE;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_AX;
            end
            ST_AX:     begin cmd.mul_op = OP_AX;  state_next = ST_AX_WB;  end
            ST_AX_WB:  begin cmd.wb_op  = OP_AX;  state_next = ST_AY;     end
            ST_AY:     begin cmd.mul_op = OP_AY;  state_next = ST_AY_WB;  end
            ST_AY_WB:  begin cmd.wb_op  = OP_AY;  state_next = ST_SQX;    end
            ST_SQX:    begin cmd.mul_op = OP_SQX; state_next = ST_SQX_WB; end
            ST_SQX_WB: begin cmd.wb_op  = OP_SQX; state_next = ST_SQY;    end
            ST_SQY:    begin cmd.mul_op = OP_SQY; state_next = ST_SQY_WB; end
            ST_SQY_WB: begin cmd.wb_op  = OP_SQY; state_next = ST_ROOT;   end
            ST_ROOT: begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (!status.root_busy) begin
                    state_next = ST_ENV;
                end
            end
            ST_ENV:    begin cmd.mul_op = OP_ENV; state_next = ST_ENV_WB; end
            ST_ENV_WB: begin cmd.wb_op  = OP_ENV; state_next = ST_FAC;    end
            ST_FAC:    begin cmd.mul_op = OP_FAC; state_next = ST_FAC_WB; end
            ST_FAC_WB: begin cmd.wb_op  = OP_FAC; state_next = ST_SCX;    end
            ST_SCX:    begin cmd.mul_op = OP_SCX; state_next = ST_SCX_WB; end
            ST_SCX_WB: begin cmd.wb_op  = OP_SCX; state_next = ST_SCY;    end
            ST_SCY:    begin cmd.mul_op = OP_SCY; state_next = ST_SCY_WB; end
            ST_SCY_WB: begin cmd.wb_op  = OP_SCY; state_next = ST_ROUND;  end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the result
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pointer_motion_smoother.sv =====
// The sequencer and one shared multiplier handle a single report at a time, and the output
// register lets the next report start while a result waits. Synchronous active-low reset
// clears filter state, output valid and sets the registers to defaults.
// Top level: config registers, output register, controller and datapath (pms_pkg, pms_ctrl, pms_dp).
module pointer_motion_smoother
    import pms_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // up_count, down_count, left_count, right_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // move_y, move_x
    output logic        m_tuser,   // moved
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    res_t    result;
    logic    m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic    m_tuser_reg;
    logic [31:0] in_words;

    // datapath expects up, down, left, right from the high byte down, as s_tdata carries them
    assign in_words = {s_tdata[31:24], s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_gain       <= 12'd384;
            cfg_reg.y_gain       <= 12'd384;
            cfg_reg.hand_side    <= 1'b0;
            cfg_reg.smooth_alpha <= 16'd4915;
            cfg_reg.rise_rate    <= 16'd3277;
            cfg_reg.fall_rate    <= 16'd819;
            cfg_reg.accel_scale  <= 16'd2688;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_X_GAIN:       cfg_reg.x_gain       <= cfg_data[11:0];
                CFG_Y_GAIN:       cfg_reg.y_gain       <= cfg_data[11:0];
                CFG_HAND_SIDE:    cfg_reg.hand_side    <= cfg_data[0];
                CFG_SMOOTH_ALPHA: cfg_reg.smooth_alpha <= cfg_data;
                CFG_RISE_RATE:    cfg_reg.rise_rate    <= cfg_data;
                CFG_FALL_RATE:    cfg_reg.fall_rate    <= cfg_data;
                CFG_ACCEL_SCALE:  cfg_reg.accel_scale  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    pms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (!m_tvalid_reg || m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pms_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .in_data ({in_words[31:24], in_words[23:16], in_words[15:8], in_words[7:0]}),
        .status  (status),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {result.move_y, result.move_x};
            m_tuser_reg <= result.moved;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hw/rtl/pms_checker.sv =====
// Port-level checker for the pointer motion smoother, bound to the top level.
// Depends on pointer_motion_smoother ports only.
module pms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second report taken while one is in work");

    a_still_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 16'h0000)
        else $error("move reported without moved flag");

endmodule

bind pointer_motion_smoother pms_checker u_pms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/tb_pointer_motion_smoother.sv =====
// Self-checking bench for pointer_motion_smoother: reports go in over the stream port and
// each accepted report is predicted by a fixed-point model and checked against the result.
// Depends on pms_pkg and the pointer_motion_smoother RTL.
module tb_pointer_motion_smoother;
    import pms_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;

    typedef struct {
        logic [7:0] move_x;
        logic [7:0] move_y;
        logic       moved;
    } motion_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // up_count, down_count, left_count, right_count
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // move_y, move_x
    logic        m_tuser;        // moved
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    pointer_motion_smoother DUT (.*);

    always #1 aclk = ~aclk;

    // bench copy of the registers and filter state
    cfg_t        regs;
    int          avg_x, avg_y, resid_x, resid_y;
    int unsigned envelope;

    logic [31:0] report_q[$];
    motion_t     motion_q[$];
    int          errors = 0;
    int          n_reports = 0;
    int          n_moved = 0;
    bit          quiet = 1'b0;

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // round half away from zero, then keep the leftover in the residual
    function automatic longint scale_round(int avg, longint factor, ref int resid);
        longint scaled, r;
        scaled = ((longint'(avg) * factor) >>> FB) - longint'(resid);
        if (scaled >= 0) r = (scaled + (64'sd1 <<< (FB - 1))) >>> FB;
        else r = -((-scaled + (64'sd1 <<< (FB - 1))) >>> FB);
        resid = int'(r * (64'sd1 <<< FB) - scaled);
        return r;
    endfunction

    function automatic motion_t predict_motion(logic [31:0] rep);
        longint gx, gy, len, env, rate, factor, rx, ry, mx, my;
        motion_t m;
        gx = sat((longint'(rep[31:24]) - longint'(rep[23:16])) * longint'(regs.x_gain)
                 * (64'sd1 <<< (FB - 8)), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        gy = sat((longint'(rep[15:8]) - longint'(rep[7:0])) * longint'(regs.y_gain)
                 * (64'sd1 <<< (FB - 8)), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        avg_x = int'(longint'(avg_x) + (((gx - avg_x) * longint'(regs.smooth_alpha)) >>> 16));
        avg_y = int'(longint'(avg_y) + (((gy - avg_y) * longint'(regs.smooth_alpha)) >>> 16));
        len = longint'(isqrt(64'(gx * gx) + 64'(gy * gy)));
        env = longint'(envelope);
        rate = (len < env) ? longint'(regs.fall_rate) : longint'(regs.rise_rate);
        env = env + (((len - env) * rate) >>> 16);
        envelope = int'(sat(env, 0, 64'sd4294967295));
        factor = (longint'(envelope) * longint'(regs.accel_scale)) >>> 8;
        factor = sat(factor, 64'sd1 <<< FB, 64'sd2147483647);
        rx = scale_round(avg_x, factor, resid_x);
        ry = scale_round(avg_y, factor, resid_y);
        if (regs.hand_side == 1'b0) begin
            mx = ry; my = -rx;
        end else begin
            mx = -ry; my = rx;
        end
        m.move_x = 8'(sat(mx, -128, 127));
        m.move_y = 8'(sat(my, -128, 127));
        m.moved  = (rx != 0 || ry != 0);
        return m;
    endfunction

    // driver: predict on each transfer, then present the next report or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                motion_q.push_back(predict_motion(s_tdata));
                n_reports++;
            end
            if (report_q.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= report_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure and in-order compare
    always @(posedge aclk) begin
        motion_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (motion_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d moved=%0b", $time,
                         $signed(m_tdata[7:0]), $signed(m_tdata[15:8]), m_tuser);
                errors++;
            end else begin
                e = motion_q.pop_front();
                if (m_tuser) n_moved++;
                if (m_tdata[7:0] !== e.move_x) begin
                    $display("%0t: move_x expected %0d actual %0d", $time,
                             $signed(e.move_x), $signed(m_tdata[7:0]));
                    errors++;
                end
                if (m_tdata[15:8] !== e.move_y) begin
                    $display("%0t: move_y expected %0d actual %0d", $time,
                             $signed(e.move_y), $signed(m_tdata[15:8]));
                    errors++;
                end
                if (m_tuser !== e.moved) begin
                    $display("%0t: moved expected %0b actual %0b", $time, e.moved, m_tuser);
                    errors++;
                end
            end
        end
        m_tready <= quiet || ($urandom_range(99) >= 9);
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_X_GAIN:       regs.x_gain       = val[11:0];
            CFG_Y_GAIN:       regs.y_gain       = val[11:0];
            CFG_HAND_SIDE:    regs.hand_side    = val[0];
            CFG_SMOOTH_ALPHA: regs.smooth_alpha = val;
            CFG_RISE_RATE:    regs.rise_rate    = val;
            CFG_FALL_RATE:    regs.fall_rate    = val;
            CFG_ACCEL_SCALE:  regs.accel_scale  = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] xg, logic [15:0] yg, logic hs, logic [15:0] al,
                             logic [15:0] rr, logic [15:0] fr, logic [15:0] sc);
        write_reg(CFG_X_GAIN, xg);
        write_reg(CFG_Y_GAIN, yg);
        write_reg(CFG_HAND_SIDE, {15'($urandom), hs});
        write_reg(CFG_SMOOTH_ALPHA, al);
        write_reg(CFG_RISE_RATE, rr);
        write_reg(CFG_FALL_RATE, fr);
        write_reg(CFG_ACCEL_SCALE, sc);
        write_reg(3'd7, 16'($urandom));   // unused index, must be ignored
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender holds off until the block has drained, plus its latency
    task automatic drain();
        while (report_q.size() > 0 || s_tvalid || motion_q.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [7:0] tick_count();
        return ($urandom_range(99) < 75) ? 8'($urandom_range(6)) : 8'($urandom);
    endfunction

    task automatic push_random(int n);
        repeat (n) report_q.push_back({tick_count(), tick_count(), tick_count(), tick_count()});
    endtask

    initial begin
        regs = '{x_gain: 12'd384, y_gain: 12'd384, hand_side: 1'b0, smooth_alpha: 16'd4915,
                 rise_rate: 16'd3277, fall_rate: 16'd819, accel_scale: 16'd2688};
        avg_x = 0; avg_y = 0; resid_x = 0; resid_y = 0; envelope = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: no motion, each direction alone, extremes
        report_q.push_back(32'h0000_0000);
        report_q.push_back(32'h0000_0001);
        report_q.push_back(32'h0000_0100);
        report_q.push_back(32'h0001_0000);
        report_q.push_back(32'h0100_0000);
        report_q.push_back(32'hFF00_0000);
        report_q.push_back(32'h00FF_0000);
        report_q.push_back(32'h0000_FF00);
        report_q.push_back(32'h0000_00FF);
        report_q.push_back(32'hFFFF_FFFF);
        report_q.push_back(32'hFF00_FF00);
        report_q.push_back(32'h00FF_00FF);
        repeat (4) report_q.push_back(32'h0000_0000);
        drain();

        // max gains and rates, left hand: saturation path
        write_all(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        report_q.push_back(32'hFF00_FF00);
        report_q.push_back(32'h00FF_00FF);
        report_q.push_back(32'h0200_0100);
        report_q.push_back(32'h0000_0000);
        drain();

        // all zero: nothing moves
        write_all(16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        report_q.push_back(32'hFF00_00FF);
        report_q.push_back(32'h00FF_FF00);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                write_all(16'd384, 16'd384, 1'b1, 16'd4915, 16'd3277, 16'd819, 16'd2688);
            end else begin
                write_all(16'($urandom_range(1023)), 16'($urandom_range(1023)),
                          1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095)));
            end
            quiet = (ph == 3);
            push_random(88);
            drain();
        end
        quiet = 1'b0;

        $display("Sent %0d reports (%0d with motion) over nine register settings,", n_reports,
                 n_moved);
        $display("including zero and full-scale registers and both hand sides.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding", motion_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
